// ===== src/ph_reading_stability_detector_core_macros.svh =====
// Assertion macros shared by the stability detector RTL.
`ifndef PH_READING_STABILITY_DETECTOR_CORE_MACROS_SVH
`define PH_READING_STABILITY_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PRSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prsd assertion failed");

// Next-cycle implication, checked out of reset.
`define PRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prsd assertion failed");

`endif

// ===== src/prsd_pkg.sv =====
// Package: widths, defaults and register map of the pH stability detector.
package prsd_pkg;

    localparam int ADC_W     = 10;
    localparam int SLOPE_W   = 20;
    localparam int OFFSET_W  = 13;
    localparam int BAND_W    = 23;
    localparam int DIFF_W    = 14;
    localparam int PROD_W    = SLOPE_W + DIFF_W;
    localparam int PH_W      = 24;
    localparam int DELTA_W   = PH_W + 1;
    localparam int SUM_W     = PH_W + 1;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam int WINDOW_LEN_DEF   = 10;
    localparam int SETTLE_LIMIT_DEF = 10;

    localparam logic [BAND_W-1:0]        STABLE_BAND_RST = 23'd3277;
    localparam logic signed [PROD_W-1:0] PH_MAX = 34'sd8388607;
    localparam logic signed [PROD_W-1:0] PH_MIN = -34'sd8388608;

    typedef enum logic [1:0] {
        REG_SLOPE_GAIN  = 2'd0,
        REG_ADC_OFFSET  = 2'd1,
        REG_STABLE_BAND = 2'd2
    } cfg_idx_t;

endpackage

// ===== src/prsd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module prsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ph_reading_stability_detector_core.sv =====
// Top level: pH reading from ADC code plus windowed stability flag.
//
// Input channel (in_valid/in_ready) carries one adc_code per item; output
// channel (out_valid/out_ready) returns ph_value (signed Q8.16, saturated)
// and is_stable for every item, in order.
// Stage 1 registers slope_gain * (adc_code - adc_offset) and issues the
// ring read for the oldest delta; stage 2 saturates, updates the running
// sum, compares with the band and loads the output register.
// An accepted item is registered in stage 1 and then in the output register.
// Throughput: one item per cycle while out_ready is high; the multiply stage
// and the sum/compare stage each hold one item, so the input side can take
// one more item while a finished result waits in the output register.
// When out_ready is low the output register holds and stage 1 still takes
// one more item; in_ready drops only once both stages are full.
// Reset (rst_n low, asynchronous): registers return to slope 0, offset 0,
// band 3277, the window and the settle counter clear; the delta ring is
// treated as all zero until it has been filled once, with no clearing pass.
// Config is an APB-style port: slope_gain at 0x0, adc_offset at 0x4,
// stable_band at 0x8; pready is always high.
`include "ph_reading_stability_detector_core_macros.svh"

module ph_reading_stability_detector_core #(
    parameter int WINDOW_LEN   = prsd_pkg::WINDOW_LEN_DEF,
    parameter int SETTLE_LIMIT = prsd_pkg::SETTLE_LIMIT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [prsd_pkg::APB_AW-1:0]        paddr,
    input  logic [prsd_pkg::APB_DW-1:0]        pwdata,
    output logic [prsd_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [prsd_pkg::ADC_W-1:0]         adc_code,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [prsd_pkg::PH_W-1:0]   ph_value,
    output logic                               is_stable
);

    import prsd_pkg::*;

    localparam int POS_W = $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(SETTLE_LIMIT + 2);

    // Configuration registers
    logic signed [SLOPE_W-1:0]  slope_gain_reg;
    logic signed [OFFSET_W-1:0] adc_offset_reg;
    logic [BAND_W-1:0]          stable_band_reg;
    cfg_idx_t                   cfg_idx;
    logic                       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = cfg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_gain_reg  <= '0;
            adc_offset_reg  <= '0;
            stable_band_reg <= STABLE_BAND_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SLOPE_GAIN:  slope_gain_reg  <= pwdata[SLOPE_W-1:0];
                REG_ADC_OFFSET:  adc_offset_reg  <= pwdata[OFFSET_W-1:0];
                REG_STABLE_BAND: stable_band_reg <= pwdata[BAND_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SLOPE_GAIN:
                prdata = {{(APB_DW-SLOPE_W){slope_gain_reg[SLOPE_W-1]}}, slope_gain_reg};
            REG_ADC_OFFSET:
                prdata = {{(APB_DW-OFFSET_W){adc_offset_reg[OFFSET_W-1]}}, adc_offset_reg};
            REG_STABLE_BAND:
                prdata = {{(APB_DW-BAND_W){1'b0}}, stable_band_reg};
            default:
                prdata = '0;
        endcase
    end

    // Handshake and pipeline control
    logic s1_valid_reg;
    logic out_valid_reg;
    logic in_acc;
    logic adv;

    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;
    assign in_acc   = in_valid && in_ready;

    // Stage 1: offset subtract and scale
    logic signed [DIFF_W-1:0] code_s;
    logic signed [DIFF_W-1:0] offset_s;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;

    assign code_s   = {{(DIFF_W-ADC_W){1'b0}}, adc_code};
    assign offset_s = {{(DIFF_W-OFFSET_W){adc_offset_reg[OFFSET_W-1]}}, adc_offset_reg};
    assign diff     = code_s - offset_s;
    assign prod     = slope_gain_reg * diff;

    logic signed [PROD_W-1:0] s1_prod_reg;
    logic [POS_W-1:0]         s1_pos_reg;
    logic                     s1_old_valid_reg;
    logic [POS_W-1:0]         rd_pos_reg;
    logic                     rd_full_reg;
    logic [POS_W-1:0]         rd_pos_next;
    logic                     rd_wrap;

    assign rd_wrap     = (rd_pos_reg == POS_W'(WINDOW_LEN - 1));
    assign rd_pos_next = rd_wrap ? '0 : rd_pos_reg + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s1_old_valid_reg <= 1'b0;
            rd_pos_reg       <= '0;
            rd_full_reg      <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg     <= 1'b1;
                // ring entry at this position is real only once the ring wrapped
                s1_old_valid_reg <= rd_full_reg;
                rd_pos_reg       <= rd_pos_next;
                if (rd_wrap)
                begin
                    rd_full_reg <= 1'b1;
                end
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_prod_reg <= prod;
            s1_pos_reg  <= rd_pos_reg;
        end
    end

    // Delta ring
    logic signed [DELTA_W-1:0] ring_rdata;
    logic signed [DELTA_W-1:0] delta;

    prsd_ram #(
        .WIDTH (DELTA_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .clk   (clk),
        .we    (adv),
        .waddr (s1_pos_reg),
        .wdata (delta),
        .re    (in_acc),
        .raddr (rd_pos_reg),
        .rdata (ring_rdata)
    );

    // Stage 2: saturate, window sum, band check
    logic signed [PH_W-1:0]    prev_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]          settle_cnt_reg;
    logic signed [PH_W-1:0]    ph_sat;
    logic signed [DELTA_W-1:0] old_delta;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SUM_W:0]     sum_ext;
    logic signed [SUM_W:0]     band_s;
    logic                      in_band;
    logic [CNT_W-1:0]          cnt_inc;
    logic                      stable_next;
    logic [CNT_W-1:0]          settle_cnt_next;

    always_comb
    begin
        if (s1_prod_reg > PH_MAX)
        begin
            ph_sat = PH_MAX[PH_W-1:0];
        end
        else if (s1_prod_reg < PH_MIN)
        begin
            ph_sat = PH_MIN[PH_W-1:0];
        end
        else
        begin
            ph_sat = s1_prod_reg[PH_W-1:0];
        end
    end

    assign delta     = {ph_sat[PH_W-1], ph_sat} - {prev_reg[PH_W-1], prev_reg};
    assign old_delta = s1_old_valid_reg ? ring_rdata : '0;
    // window sum is current reading minus the one a window ago: fits SUM_W
    assign sum_wide  = {sum_reg[SUM_W-1], sum_reg} - {old_delta[DELTA_W-1], old_delta}
                     + {delta[DELTA_W-1], delta};
    assign sum_next  = sum_wide[SUM_W-1:0];
    assign sum_ext   = {sum_next[SUM_W-1], sum_next};
    assign band_s    = {{(SUM_W+1-BAND_W){1'b0}}, stable_band_reg};
    assign in_band   = (sum_ext < band_s) && (sum_ext > -band_s);
    assign cnt_inc   = in_band ? settle_cnt_reg + CNT_W'(1) : '0;
    assign stable_next     = (cnt_inc > CNT_W'(SETTLE_LIMIT));
    assign settle_cnt_next = stable_next ? CNT_W'(SETTLE_LIMIT) : cnt_inc;

    logic signed [PH_W-1:0] ph_value_reg;
    logic                   is_stable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prev_reg       <= '0;
            sum_reg        <= '0;
            settle_cnt_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg  <= 1'b1;
                prev_reg       <= ph_sat;
                sum_reg        <= sum_next;
                settle_cnt_reg <= settle_cnt_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ph_value_reg  <= ph_sat;
            is_stable_reg <= stable_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign ph_value  = ph_value_reg;
    assign is_stable = is_stable_reg;

    `PRSD_ASSERT_NOW(a_cnt_limit, clk, rst_n, 1'b1, settle_cnt_reg <= CNT_W'(SETTLE_LIMIT))
    `PRSD_ASSERT_NOW(a_pos_range, clk, rst_n, 1'b1, rd_pos_reg <= POS_W'(WINDOW_LEN - 1))
    `PRSD_ASSERT_NOW(a_full_accept, clk, rst_n, in_acc && s1_valid_reg, adv)
    `PRSD_ASSERT_NOW(a_stable_cnt, clk, rst_n, out_valid_reg && is_stable_reg,
                     settle_cnt_reg == CNT_W'(SETTLE_LIMIT))
    `PRSD_ASSERT_NEXT(a_zero_band, clk, rst_n, adv && (stable_band_reg == '0),
                      settle_cnt_reg == '0 && !is_stable_reg)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the pH reading stability detector core.
`timescale 1ns / 100ps

module testbench;
    import prsd_pkg::*;

    localparam int WINDOW       = WINDOW_LEN_DEF;
    localparam int SETTLE_MAX   = SETTLE_LIMIT_DEF;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 220;
    localparam int RANDOM_PHASES = 8;
    localparam int RX_HOLD_LEN  = 80;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    typedef struct {
        logic signed [PH_W-1:0] ph;
        logic                   stable;
    } reading_t;

    class ph_scoreboard;
        logic signed [SLOPE_W-1:0]  slope;
        logic signed [OFFSET_W-1:0] offset;
        logic [BAND_W-1:0]          band;
        logic signed [PH_W-1:0]     last_ph;
        longint                     deltas[WINDOW];
        longint                     window_sum;
        int                         slot;
        int                         settle;
        reading_t                   pending[$];
        int                         errors;

        function void reset_state();
            slope      = '0;
            offset     = '0;
            band       = STABLE_BAND_RST;
            last_ph    = '0;
            window_sum = 0;
            slot       = 0;
            settle     = 0;
            errors     = 0;
            foreach (deltas[i])
                deltas[i] = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            if (idx == REG_SLOPE_GAIN)
                slope = value[SLOPE_W-1:0];
            else if (idx == REG_ADC_OFFSET)
                offset = value[OFFSET_W-1:0];
            else if (idx == REG_STABLE_BAND)
                band = value[BAND_W-1:0];
        endfunction

        function void note_sample(logic [ADC_W-1:0] code);
            longint   diff;
            longint   prod;
            longint   delta;
            reading_t r;
            diff = longint'(code) - longint'(offset);
            prod = longint'(slope) * diff;
            if (prod > 64'sd8388607)
                prod = 64'sd8388607;
            if (prod < -64'sd8388608)
                prod = -64'sd8388608;
            r.ph = prod[PH_W-1:0];
            delta = longint'(r.ph) - longint'(last_ph);
            window_sum = window_sum - deltas[slot] + delta;
            deltas[slot] = delta;
            last_ph = r.ph;
            slot = (slot + 1) % WINDOW;
            if (window_sum > -longint'(band) && window_sum < longint'(band))
                settle++;
            else
                settle = 0;
            r.stable = (settle > SETTLE_MAX);
            if (r.stable)
                settle = SETTLE_MAX;
            pending.push_back(r);
        endfunction

        function void check_result(logic signed [PH_W-1:0] ph, logic stable);
            reading_t r;
            if (pending.size() == 0)
            begin
                $error("unexpected result: ph_value %0d is_stable %0b", ph, stable);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (ph !== r.ph)
            begin
                $error("ph_value mismatch: expected %0d, actual %0d", r.ph, ph);
                errors++;
            end
            if (stable !== r.stable)
            begin
                $error("is_stable mismatch: expected %0b, actual %0b", r.stable, stable);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_ready;
    logic [ADC_W-1:0]          adc_code;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [PH_W-1:0]    ph_value;
    logic                      is_stable;

    ph_scoreboard sb = new;
    bit           no_idle;
    int           hold_req = 0;
    int           hold_ack = 0;
    int           rx_hold = 0;
    int           stall_cycles = 0;

    ph_reading_stability_detector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .adc_code  (adc_code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ph_value  (ph_value),
        .is_stable (is_stable)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // receiver: random back-pressure, plus a forced hold-off counted down here
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            rx_hold  = RX_HOLD_LEN;
        end
        if (rx_hold > 0)
        begin
            out_ready = 1'b0;
            rx_hold--;
        end
        else
        begin
            out_ready = no_idle || ($urandom_range(0, 99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_sample(adc_code);
            if (out_valid && out_ready)
                sb.check_result(ph_value, is_stable);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic configure(input int slope, input int offset, input int band);
        write_reg(REG_SLOPE_GAIN, 32'(slope));
        write_reg(REG_ADC_OFFSET, 32'(offset));
        write_reg(REG_STABLE_BAND, 32'(band));
    endtask

    // returns just after the posedge at which the item is taken
    task automatic send_sample(input int code);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 22)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        adc_code = code[ADC_W-1:0];
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_config(input int phase);
        int slope;
        int offset;
        int band;
        if (phase == 0)
        begin
            configure(524287, -4096, 8388607);
        end
        else if (phase == 1)
        begin
            configure(-524288, 4095, 0);
        end
        else
        begin
            if ($urandom_range(0, 1) == 0)
                slope = $urandom_range(0, 8000);
            else
                slope = $urandom_range(0, 1048575);
            if (slope >= 524288)
                slope -= 1048576;
            else if ($urandom_range(0, 1) == 0)
                slope = -slope;
            offset = $urandom_range(0, 8191);
            if (offset >= 4096)
                offset -= 8192;
            case ($urandom_range(0, 2))
                0: band = $urandom_range(0, 8000);
                1: band = $urandom_range(0, 1 << 20);
                default: band = $urandom_range(0, 8388607);
            endcase
            configure(slope, offset, band);
        end
    endtask

    // mostly slowly varying runs so the settle counter can saturate; some raw noise
    task automatic random_stream(input int count, input int pause_at);
        int sent;
        int cur;
        int len;
        int r;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                cur = $urandom_range(0, 1023);
                len = $urandom_range(12, 40);
                if (len > count - sent)
                    len = count - sent;
                repeat (len)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        cur--;
                    else if (r == 1)
                        cur++;
                    else if (r == 2)
                        cur += $urandom_range(0, 20) - 10;
                    if (cur < 0)
                        cur = 0;
                    if (cur > 1023)
                        cur = 1023;
                    send_sample(cur);
                    sent++;
                    if (sent == pause_at)
                        wait_results_done();
                end
            end
            else
            begin
                len = $urandom_range(1, 8);
                if (len > count - sent)
                    len = count - sent;
                repeat (len)
                begin
                    send_sample($urandom_range(0, 1023));
                    sent++;
                    if (sent == pause_at)
                        wait_results_done();
                end
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        adc_code  = '0;
        no_idle   = 1'b0;
        sb.reset_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: zero slope keeps every reading at 0, so the flag must rise
        for (int i = 0; i < 12; i++)
            send_sample((i % 2 == 0) ? 0 : 1023);
        wait_results_done();

        // saturation both ways; unmapped register write must be ignored
        configure(524287, -4096, 8388607);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_sample(0);
        send_sample(1023);
        send_sample(512);
        send_sample(1023);
        wait_results_done();
        configure(-524288, -4096, 8388607);
        send_sample(1023);
        send_sample(0);
        send_sample(511);
        send_sample(1023);
        wait_results_done();

        // zero band: nothing is strictly inside, flag stays low
        configure(1, 0, 0);
        for (int i = 0; i < 5; i++)
            send_sample(5);
        wait_results_done();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_config(p);
            no_idle = (p == 5);
            if (p == 2)
                hold_req++;
            random_stream(PHASE_ITEMS, (p == 4) ? 100 : -1);
            wait_results_done();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/prsd_pkg.sv
src/prsd_ram.sv
src/ph_reading_stability_detector_core.sv
tb/testbench.sv
